@@ design/scl_pkg.sv @@
// Shared types, constants and character helpers for the command line matcher.
package scl_pkg;

   localparam int LINE_BYTES_DEF   = 64;
   localparam int MAX_COMMANDS_DEF = 6;
   localparam int CMD_CHARS_DEF    = 8;

   localparam int CHAR_W     = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;
   localparam int CMD_IDX_W  = 3;
   localparam int CMD_CNT_W  = 3;

   localparam logic [CHAR_W-1:0] TERMINATOR_RST = 8'd13;

   localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
   localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
   localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
   localparam logic [CHAR_W-1:0] CH_COLON  = 8'h3A;
   localparam logic [CHAR_W-1:0] CH_EQUALS = 8'h3D;
   localparam logic [CHAR_W-1:0] CH_PRINT_LO = 8'h20;
   localparam logic [CHAR_W-1:0] CH_PRINT_HI = 8'h7E;
   localparam logic [CHAR_W-1:0] CH_LOWER_A  = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LOWER_Z  = 8'h7A;
   localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'h20;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_TERMINATOR = 3'd0,
      REG_CMD_COUNT  = 3'd1,
      REG_CMD_WORD0  = 3'd2
   } csr_reg_type;

   typedef enum logic [1:0] {
      OUT_EMPTY = 2'd0,
      OUT_MATCH = 2'd1,
      OUT_MISS  = 2'd2
   } outcome_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SKIP,
      ST_TOKEN,
      ST_COMPARE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic wr_en;
      logic clear_all;
   } store_ctl_type;

   function automatic logic is_delim(input logic [CHAR_W-1:0] c);
      return (c == CH_SPACE) || (c == CH_DOT) || (c == CH_COMMA) ||
             (c == CH_COLON) || (c == CH_EQUALS);
   endfunction

   function automatic logic is_printable(input logic [CHAR_W-1:0] c);
      return (c >= CH_PRINT_LO) && (c <= CH_PRINT_HI);
   endfunction

   function automatic logic [CHAR_W-1:0] to_upper(input logic [CHAR_W-1:0] c);
      if ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) begin
         return c - CASE_OFFSET;
      end
      return c;
   endfunction

endpackage

@@ design/scl_line_store.sv @@
// Line buffer: byte memory with per-entry valid flags and a registered read port.
module scl_line_store #(
   parameter int LINE_BYTES = scl_pkg::LINE_BYTES_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  scl_pkg::store_ctl_type                ctl,
   input  logic [$clog2(LINE_BYTES+1)-1:0]       wr_addr,
   input  logic [scl_pkg::CHAR_W-1:0]            wr_data,
   input  logic [$clog2(LINE_BYTES+1)-1:0]       rd_addr,
   output logic [scl_pkg::CHAR_W-1:0]            rd_data
);
   import scl_pkg::*;

   localparam int DEPTH  = LINE_BYTES + 1;
   localparam int ADDR_W = $clog2(DEPTH);

   logic [CHAR_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]  valid_ff, valid_in;
   logic [CHAR_W-1:0] rd_mem_ff;
   logic              rd_valid_ff;
   logic [ADDR_W-1:0] mark_addr;

   // the end mark goes one past the written byte; wr_addr never exceeds LINE_BYTES-1
   assign mark_addr = wr_addr + ADDR_W'(1);

   always_comb begin
      valid_in = valid_ff;
      if (ctl.clear_all) begin
         valid_in = '0;
      end
      if (ctl.wr_en) begin
         valid_in[wr_addr]   = 1'b1;
         valid_in[mark_addr] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_mem_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= valid_ff[rd_addr];
         valid_ff    <= valid_in;
      end
   end

   assign rd_data = rd_valid_ff ? rd_mem_ff : '0;

endmodule

@@ design/scl_cmd_compare.sv @@
// Shared compare unit: uppercased token against one command word, bounded like strncmp.
module scl_cmd_compare #(
   parameter int CMD_CHARS = scl_pkg::CMD_CHARS_DEF
) (
   input  logic [CMD_CHARS*scl_pkg::CHAR_W-1:0] tok,
   input  logic [$clog2(CMD_CHARS+1)-1:0]       tok_len,
   input  logic [scl_pkg::CSR_DATA_W-1:0]       word,
   output logic                                 hit
);
   import scl_pkg::*;

   // positions up to and including the token's terminating zero must agree
   always_comb begin
      hit = 1'b1;
      for (int k = 0; k < CMD_CHARS; k++) begin
         if ((k <= int'(tok_len)) &&
             (to_upper(tok[k*CHAR_W +: CHAR_W]) != word[k*CHAR_W +: CHAR_W])) begin
            hit = 1'b0;
         end
      end
   end

endmodule

@@ design/serial_command_line_matcher.sv @@
// Top level: byte intake, token scan sequencer, command search and result register.
// Intake: a non-terminator byte is taken while idle, and req_ready stays high for the next one.
// A terminator starts a scan of up to LINE_BYTES+1 buffer bytes, one at a time through the
// single line store read port, then tries the command words one by one in the shared compare
// unit, then posts the result, waiting while an earlier result is still held; throughout
// that time req_ready is low.
// Reset: synchronous, clears the store's valid flags at once (no clearing pass) and all control.
module serial_command_line_matcher #(
   parameter int LINE_BYTES   = scl_pkg::LINE_BYTES_DEF,
   parameter int MAX_COMMANDS = scl_pkg::MAX_COMMANDS_DEF,
   parameter int CMD_CHARS    = scl_pkg::CMD_CHARS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [scl_pkg::CHAR_W-1:0]        req_rx_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [1:0]                        rsp_outcome,
   output logic [scl_pkg::CMD_IDX_W-1:0]     rsp_cmd_index,
   output logic [scl_pkg::CHAR_W-1:0]        rsp_single_char,
   input  logic                              csr_wr_en,
   input  logic [scl_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [scl_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import scl_pkg::*;

   localparam int ADDR_W = $clog2(LINE_BYTES + 1);
   localparam int WP_W   = $clog2(LINE_BYTES);
   localparam int LEN_W  = $clog2(CMD_CHARS + 1);
   localparam int TOK_W  = CMD_CHARS * CHAR_W;

   localparam logic [ADDR_W-1:0]    LAST_ADDR = ADDR_W'(LINE_BYTES);
   localparam logic [WP_W:0]        WP_WRAP   = (WP_W+1)'(LINE_BYTES);
   localparam logic [LEN_W-1:0]     LEN_MAX   = LEN_W'(CMD_CHARS);
   localparam logic [CMD_IDX_W-1:0] MAX_CMD   = CMD_IDX_W'(MAX_COMMANDS);

   // configuration
   logic [CHAR_W-1:0]     terminator_ff;
   logic [CMD_CNT_W-1:0]  cmd_count_ff;
   logic [CSR_DATA_W-1:0] cmd_words_ff [MAX_COMMANDS];

   // sequencer state
   state_type             state_ff, state_in;
   logic [WP_W-1:0]       wp_ff, wp_in;
   logic [ADDR_W-1:0]     pos_ff, pos_in;
   logic [TOK_W-1:0]      tok_ff, tok_in;
   logic [LEN_W-1:0]      tok_len_ff, tok_len_in;
   logic [CMD_IDX_W-1:0]  cmd_i_ff, cmd_i_in;
   outcome_type           outcome_ff, outcome_in;
   logic [CMD_IDX_W-1:0]  idx_ff, idx_in;
   logic [CHAR_W-1:0]     single_ff, single_in;
   logic                  single_sel_ff, single_sel_in;
   logic [CHAR_W-1:0]     char_ff, char_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   outcome_type           rsp_outcome_ff, rsp_outcome_in;
   logic [CMD_IDX_W-1:0]  rsp_cmd_index_ff, rsp_cmd_index_in;
   logic [CHAR_W-1:0]     rsp_single_char_ff, rsp_single_char_in;

   // datapath links
   store_ctl_type         store_ctl;
   logic [ADDR_W-1:0]     wr_addr;
   logic [CHAR_W-1:0]     wr_data;
   logic [ADDR_W-1:0]     rd_addr;
   logic [CHAR_W-1:0]     rd_data;
   logic [CSR_DATA_W-1:0] word_sel;
   logic                  hit;
   logic [CMD_IDX_W-1:0]  cmd_limit;
   logic [WP_W:0]         wp_plus;
   logic                  take_char;

   scl_line_store #(
      .LINE_BYTES(LINE_BYTES)
   ) u_store (
      .clock  (clock),
      .reset  (reset),
      .ctl    (store_ctl),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   scl_cmd_compare #(
      .CMD_CHARS(CMD_CHARS)
   ) u_cmp (
      .tok    (tok_ff),
      .tok_len(tok_len_ff),
      .word   (word_sel),
      .hit    (hit)
   );

   always_comb begin
      word_sel = '0;
      for (int j = 0; j < MAX_COMMANDS; j++) begin
         if (int'(cmd_i_ff) == j) begin
            word_sel = cmd_words_ff[j];
         end
      end
   end

   assign cmd_limit = (cmd_count_ff > MAX_CMD) ? MAX_CMD : cmd_count_ff;
   assign wp_plus   = {1'b0, wp_ff} + (WP_W+1)'(1);

   always_comb begin
      state_in           = state_ff;
      wp_in              = wp_ff;
      pos_in             = pos_ff;
      tok_in             = tok_ff;
      tok_len_in         = tok_len_ff;
      cmd_i_in           = cmd_i_ff;
      outcome_in         = outcome_ff;
      idx_in             = idx_ff;
      single_in          = single_ff;
      single_sel_in      = single_sel_ff;
      char_in            = char_ff;
      rsp_valid_in       = rsp_valid_ff & ~rsp_ready;
      rsp_outcome_in     = rsp_outcome_ff;
      rsp_cmd_index_in   = rsp_cmd_index_ff;
      rsp_single_char_in = rsp_single_char_ff;
      store_ctl          = '0;
      wr_addr            = ADDR_W'(wp_ff);
      wr_data            = req_rx_byte;
      rd_addr            = '0;
      req_ready          = 1'b0;
      take_char          = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_rx_byte == terminator_ff) begin
                  // store address 0 is being read this cycle for the scan
                  char_in       = req_rx_byte;
                  single_sel_in = ({1'b0, wp_ff} < (WP_W+1)'(2));
                  pos_in        = '0;
                  tok_in        = '0;
                  tok_len_in    = '0;
                  cmd_i_in      = '0;
                  state_in      = ST_SKIP;
               end else if (is_printable(req_rx_byte)) begin
                  store_ctl.wr_en = 1'b1;
                  wp_in = (wp_plus == WP_WRAP) ? '0 : wp_plus[WP_W-1:0];
               end
            end
         end
         ST_SKIP: begin
            rd_addr = (pos_ff == LAST_ADDR) ? LAST_ADDR : pos_ff + ADDR_W'(1);
            if (pos_ff == '0) begin
               single_in = single_sel_ff ? rd_data : '0;
            end
            if (rd_data == '0) begin
               outcome_in = OUT_EMPTY;
               idx_in     = '0;
               state_in   = ST_DONE;
            end else if (is_delim(rd_data)) begin
               if (pos_ff == LAST_ADDR) begin
                  outcome_in = OUT_EMPTY;
                  idx_in     = '0;
                  state_in   = ST_DONE;
               end else begin
                  pos_in = pos_ff + ADDR_W'(1);
               end
            end else begin
               take_char = 1'b1;
            end
         end
         ST_TOKEN: begin
            rd_addr = (pos_ff == LAST_ADDR) ? LAST_ADDR : pos_ff + ADDR_W'(1);
            if ((rd_data == '0) || is_delim(rd_data)) begin
               state_in = ST_COMPARE;
            end else begin
               take_char = 1'b1;
            end
         end
         ST_COMPARE: begin
            if (cmd_i_ff >= cmd_limit) begin
               outcome_in = OUT_MISS;
               idx_in     = '0;
               state_in   = ST_DONE;
            end else if (hit) begin
               outcome_in = OUT_MATCH;
               idx_in     = cmd_i_ff;
               state_in   = ST_DONE;
            end else begin
               cmd_i_in = cmd_i_ff + CMD_IDX_W'(1);
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in       = 1'b1;
               rsp_outcome_in     = outcome_ff;
               rsp_cmd_index_in   = idx_ff;
               rsp_single_char_in = single_ff;
               wp_in              = '0;
               state_in           = ST_IDLE;
               // empty line keeps the buffer and drops the terminator
               if (outcome_ff != OUT_EMPTY) begin
                  store_ctl.clear_all = 1'b1;
                  if (is_printable(char_ff)) begin
                     store_ctl.wr_en = 1'b1;
                     wr_addr         = '0;
                     wr_data         = char_ff;
                     wp_in           = WP_W'(1);
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // token byte: keep up to CMD_CHARS of it, then stop at the cap or the store end
      if (take_char) begin
         for (int k = 0; k < CMD_CHARS; k++) begin
            if (int'(tok_len_ff) == k) begin
               tok_in[k*CHAR_W +: CHAR_W] = rd_data;
            end
         end
         tok_len_in = tok_len_ff + LEN_W'(1);
         if ((tok_len_in == LEN_MAX) || (pos_ff == LAST_ADDR)) begin
            state_in = ST_COMPARE;
         end else begin
            pos_in   = pos_ff + ADDR_W'(1);
            state_in = ST_TOKEN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         wp_ff         <= '0;
         rsp_valid_ff  <= 1'b0;
         terminator_ff <= TERMINATOR_RST;
         cmd_count_ff  <= '0;
         for (int j = 0; j < MAX_COMMANDS; j++) begin
            cmd_words_ff[j] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            if (csr_index == REG_TERMINATOR) begin
               terminator_ff <= csr_wdata[CHAR_W-1:0];
            end
            if (csr_index == REG_CMD_COUNT) begin
               cmd_count_ff <= csr_wdata[CMD_CNT_W-1:0];
            end
            for (int j = 0; j < MAX_COMMANDS; j++) begin
               if (int'(csr_index) == int'(REG_CMD_WORD0) + j) begin
                  cmd_words_ff[j] <= csr_wdata;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff             <= pos_in;
      tok_ff             <= tok_in;
      tok_len_ff         <= tok_len_in;
      cmd_i_ff           <= cmd_i_in;
      outcome_ff         <= outcome_in;
      idx_ff             <= idx_in;
      single_ff          <= single_in;
      single_sel_ff      <= single_sel_in;
      char_ff            <= char_in;
      rsp_outcome_ff     <= rsp_outcome_in;
      rsp_cmd_index_ff   <= rsp_cmd_index_in;
      rsp_single_char_ff <= rsp_single_char_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_outcome     = rsp_outcome_ff;
   assign rsp_cmd_index   = rsp_cmd_index_ff;
   assign rsp_single_char = rsp_single_char_ff;

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result posted outside the done state");

   a_wp_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, wp_ff} < WP_WRAP)
      else $error("write position beyond line length");

   a_cmd_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMPARE) |-> (cmd_i_ff <= MAX_CMD))
      else $error("command search ran past the word table");

   a_idx_only_on_match: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_outcome_ff != OUT_MATCH)) |-> (rsp_cmd_index_ff == '0))
      else $error("command index set without a match");

   a_no_intake_busy: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SKIP) || (state_ff == ST_TOKEN)) |-> !store_ctl.wr_en)
      else $error("store written during scan");

endmodule
